// File: design/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, protocol constants and the CRC-16/Modbus byte update for the
// Modbus RTU request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [15:0] crc_t;

	localparam int FRAME_LEN = 8;
	localparam int BODY_LEN  = 6;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [BODY_LEN-1:0][7:0] frame_body_t;

	localparam idx_t IDX_CRC_LO = idx_t'(BODY_LEN);
	localparam idx_t IDX_CRC_HI = idx_t'(FRAME_LEN - 1);

	localparam crc_t  CRC_INIT       = 16'hFFFF;
	localparam crc_t  CRC_POLY       = 16'hA001;
	localparam byte_t FN_WRITE_COIL  = 8'h05;
	localparam byte_t FN_WRITE_REG   = 8'h06;
	localparam byte_t FN_READ        = 8'h03;
	localparam byte_t MODE_ADDR_HI   = 8'h10;
	localparam byte_t READ_QTY       = 8'h08;
	localparam byte_t COIL_ON_HI     = 8'hFF;
	localparam byte_t SLAVE_ADDR_RST = 8'h01;

	typedef enum logic [1:0] {
		ACT_WRITE_COIL  = 2'd0,
		ACT_SET_MODE    = 2'd1,
		ACT_READ_STATUS = 2'd2,
		ACT_RESERVED    = 2'd3
	} act_t;

	// One byte of CRC-16/Modbus, reflected, LSB first.
	function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
		crc_t acc;
		acc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage

// File: design/mrf_if.sv
// ----------------------------------------------------------------------------
// mrf_if
// Valid/ready channels of the framer: request in, frame byte out and the
// slave address write port.
// ----------------------------------------------------------------------------
interface mrf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] relay_number;
	logic       coil_on;

	modport source (output valid, action, relay_number, coil_on, input ready);
	modport sink   (input valid, action, relay_number, coil_on, output ready);
endinterface

interface mrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface mrf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;

	modport source (output valid, slave_address, input ready);
	modport sink   (input valid, slave_address, output ready);
endinterface

// File: design/mrf_req_stage.sv
// ----------------------------------------------------------------------------
// mrf_req_stage
// Request input register and frame body builder: holds one request and
// presents the six body bytes to the serialiser.
// ----------------------------------------------------------------------------
module mrf_req_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	mrf_req_if.sink              req,
	input  mrf_pkg::byte_t       slave_addr,
	input  logic                 take,
	output logic                 body_valid,
	output mrf_pkg::frame_body_t body
);
	import mrf_pkg::*;

	logic       valid_s1;
	act_t       action_s1;
	logic [3:0] relay_s1;
	logic       coil_s1;
	byte_t      relay_lo;

	assign req.ready  = !valid_s1 || take;
	assign body_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			// drop the unused action code here
			valid_s1 <= req.valid && (req.action != ACT_RESERVED);
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1 <= act_t'(req.action);
			relay_s1  <= req.relay_number;
			coil_s1   <= req.coil_on;
		end
	end

	assign relay_lo = byte_t'({4'd0, relay_s1}) - 8'd1;

	always_comb begin
		body[0] = slave_addr;
		unique case (action_s1)
			ACT_WRITE_COIL: begin
				body[1] = FN_WRITE_COIL;
				body[2] = 8'h00;
				body[3] = relay_lo;
				body[4] = coil_s1 ? COIL_ON_HI : 8'h00;
				body[5] = 8'h00;
			end
			ACT_SET_MODE: begin
				body[1] = FN_WRITE_REG;
				body[2] = MODE_ADDR_HI;
				body[3] = relay_lo;
				body[4] = 8'h00;
				body[5] = 8'h00;
			end
			ACT_READ_STATUS: begin
				body[1] = FN_READ;
				body[2] = MODE_ADDR_HI;
				body[3] = 8'h00;
				body[4] = 8'h00;
				body[5] = READ_QTY;
			end
			default: begin
				body[1] = 8'h00;
				body[2] = 8'h00;
				body[3] = 8'h00;
				body[4] = 8'h00;
				body[5] = 8'h00;
			end
		endcase
	end

endmodule

// File: design/mrf_serializer.sv
// ----------------------------------------------------------------------------
// mrf_serializer
// Sends a loaded frame body one byte per beat, folds each body byte into a
// running CRC-16/Modbus and appends the CRC low byte then high byte.
// ----------------------------------------------------------------------------
module mrf_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 body_valid,
	input  mrf_pkg::frame_body_t body,
	output logic                 take,
	mrf_byte_if.source           frame
);
	import mrf_pkg::*;

	logic        busy_q;
	idx_t        idx_q;
	frame_body_t body_q;
	crc_t        crc_q;
	logic        ov_q;
	byte_t       ob_q;
	logic        ol_q;
	logic        emit;
	logic        at_end;
	byte_t       cur_byte;

	assign emit   = busy_q && (!ov_q || frame.ready);
	assign at_end = (idx_q == IDX_CRC_HI);
	assign take   = body_valid && (!busy_q || (emit && at_end));

	assign frame.valid      = ov_q;
	assign frame.frame_byte = ob_q;
	assign frame.last_byte  = ol_q;

	always_comb begin
		unique case (idx_q)
			IDX_CRC_LO: cur_byte = crc_q[7:0];
			IDX_CRC_HI: cur_byte = crc_q[15:8];
			default:    cur_byte = body_q[idx_q];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + idx_t'(1);
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (frame.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			body_q <= body;
			crc_q  <= CRC_INIT;
		end else if (emit && (idx_q < IDX_CRC_LO)) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
		if (emit) begin
			ob_q <= cur_byte;
			ol_q <= at_end;
		end
	end

endmodule

// File: design/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Turns each request into an 8-byte Modbus RTU frame with CRC-16/Modbus.
// ----------------------------------------------------------------------------
// Channels: req takes one request beat (action, relay_number, coil_on); frame
// gives eight byte beats per request, slave address first, CRC low then high
// byte last, with last_byte high on the eighth. cfg writes the slave address
// (reset value 1); write it only while the block is idle.
// A request beat passes the request register, the serialiser body register
// and the output register in turn. Throughput: one byte per cycle while the
// receiver keeps ready high; the request register takes the next request
// while the current frame is still going out, so frames follow each other
// without a gap. The CRC advances one body byte per cycle with the serialiser
// and stalls with it. The unused action code is accepted and dropped.
// Reset clears the request register, serialiser and output register; no
// frame is in flight afterwards. When the receiver holds ready low the output
// byte holds, the serialiser stalls and req.ready falls once a request waits.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer (
	input  logic        clk,
	input  logic        arst_n,
	mrf_cfg_if.sink     cfg,
	mrf_req_if.sink     req,
	mrf_byte_if.source  frame
);
	import mrf_pkg::*;

	byte_t       slave_addr_q;
	logic        body_valid;
	logic        take;
	frame_body_t body;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
		end else if (cfg.valid) begin
			slave_addr_q <= cfg.slave_address;
		end
	end

	mrf_req_stage u_req_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.slave_addr (slave_addr_q),
		.take       (take),
		.body_valid (body_valid),
		.body       (body)
	);

	mrf_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.body_valid (body_valid),
		.body       (body),
		.take       (take),
		.frame      (frame)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Modbus RTU requests into the framer under bursty traffic and a
// stalling byte receiver. Each frame byte is checked against a frame built
// from the request and the current slave address, with the CRC worked out
// here. The slave address is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import mrf_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int N_DIRECTED = 16;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]  act;
		logic [3:0]  relay;
		logic        coil;
		logic        typed;
		logic [47:0] body;
	} req_row_t;

	typedef struct packed {
		byte_t data;
		logic  last;
	} frame_beat_t;

	logic clk;
	logic arst_n;

	mrf_cfg_if  cfg_ch ();
	mrf_req_if  req_ch ();
	mrf_byte_if byte_ch ();

	modbus_rtu_request_framer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.frame  (byte_ch)
	);

	frame_beat_t frame_due [$];
	byte_t       slave_now;
	int          errors;
	int          hold_ask;

	// Directed requests at the reset address; typed bodies are read straight
	// off the frame layout, the CRC is always worked out.
	req_row_t dir_rows [N_DIRECTED] = '{
		{ACT_WRITE_COIL,  4'd1,  1'b1, 1'b1, 48'h01_05_00_00_FF_00},
		{ACT_WRITE_COIL,  4'd1,  1'b0, 1'b1, 48'h01_05_00_00_00_00},
		{ACT_WRITE_COIL,  4'd8,  1'b1, 1'b1, 48'h01_05_00_07_FF_00},
		{ACT_SET_MODE,    4'd1,  1'b0, 1'b1, 48'h01_06_10_00_00_00},
		{ACT_SET_MODE,    4'd8,  1'b0, 1'b1, 48'h01_06_10_07_00_00},
		{ACT_READ_STATUS, 4'd5,  1'b1, 1'b1, 48'h01_03_10_00_00_08},
		{ACT_UNUSED,      4'd3,  1'b1, 1'b1, 48'h0},
		{ACT_WRITE_COIL,  4'd0,  1'b1, 1'b1, 48'h01_05_00_FF_FF_00},
		{ACT_WRITE_COIL,  4'd15, 1'b0, 1'b1, 48'h01_05_00_0E_00_00},
		{ACT_SET_MODE,    4'd0,  1'b1, 1'b1, 48'h01_06_10_FF_00_00},
		{ACT_SET_MODE,    4'd9,  1'b0, 1'b1, 48'h01_06_10_08_00_00},
		{ACT_READ_STATUS, 4'd15, 1'b0, 1'b1, 48'h01_03_10_00_00_08},
		{ACT_READ_STATUS, 4'd0,  1'b1, 1'b1, 48'h01_03_10_00_00_08},
		{ACT_UNUSED,      4'd15, 1'b0, 1'b1, 48'h0},
		{ACT_WRITE_COIL,  4'd4,  1'b1, 1'b0, 48'h0},
		{ACT_SET_MODE,    4'd3,  1'b1, 1'b0, 48'h0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// CRC-16/Modbus over the six body bytes, first byte in the top bits.
	function automatic crc_t body_crc(input logic [47:0] body);
		crc_t  acc;
		byte_t b;
		acc = CRC_INIT;
		for (int k = 0; k < BODY_LEN; k++) begin
			b = body[47 - 8*k -: 8];
			acc = acc ^ {8'h00, b};
			for (int i = 0; i < 8; i++) begin
				acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
			end
		end
		return acc;
	endfunction

	// Frame body for one request; returns 0 where the action sends nothing.
	function automatic logic frame_body(input byte_t addr, input logic [1:0] act,
			input logic [3:0] relay, input logic coil, output logic [47:0] body);
		byte_t relay_lo;
		relay_lo = {4'h0, relay} - 8'd1;
		body = '0;
		case (act)
			ACT_WRITE_COIL: begin
				body = {addr, FN_WRITE_COIL, 8'h00, relay_lo, coil ? COIL_ON_HI : 8'h00,
					8'h00};
			end
			ACT_SET_MODE: begin
				body = {addr, FN_WRITE_REG, MODE_ADDR_HI, relay_lo, 16'h0000};
			end
			ACT_READ_STATUS: begin
				body = {addr, FN_READ, MODE_ADDR_HI, 16'h0000, READ_QTY};
			end
			default: begin
				return 1'b0;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic void queue_frame(input logic [47:0] body);
		crc_t crc;
		crc = body_crc(body);
		for (int k = 0; k < BODY_LEN; k++) begin
			frame_due.push_back('{data: body[47 - 8*k -: 8], last: 1'b0});
		end
		frame_due.push_back('{data: crc[7:0], last: 1'b0});
		frame_due.push_back('{data: crc[15:8], last: 1'b1});
	endfunction

	// Offer one request beat and hold it until taken; valid stays high.
	task automatic send_req(input logic [1:0] act, input logic [3:0] relay,
			input logic coil, input logic typed, input logic [47:0] body);
		logic [47:0] built;
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.relay_number <= relay;
		req_ch.coil_on      <= coil;
		do @(posedge clk); while (!req_ch.ready);
		if (act != ACT_UNUSED) begin
			if (typed) begin
				queue_frame(body);
			end else if (frame_body(slave_now, act, relay, coil, built)) begin
				queue_frame(built);
			end
		end
	endtask

	task automatic pick_req(output logic [1:0] act, output logic [3:0] relay,
			output logic coil);
		if ($urandom_range(0, 99) < 6) begin
			act = ACT_UNUSED;
		end else begin
			act = 2'($urandom_range(0, 2));
		end
		if ($urandom_range(0, 9) == 0) begin
			relay = 4'($urandom_range(0, 15));
		end else begin
			relay = 4'($urandom_range(1, 8));
		end
		coil = 1'($urandom_range(0, 1));
	endtask

	// Random requests in bursts; max_gap of 0 sends them back to back.
	task automatic run_stream(input int n_framed, input int max_gap);
		int         sent;
		int         burst_left;
		logic [1:0] act;
		logic [3:0] relay;
		logic       coil;
		sent = 0;
		burst_left = $urandom_range(1, 12);
		while (sent < n_framed) begin
			pick_req(act, relay, coil);
			send_req(act, relay, coil, 1'b0, 48'h0);
			if (act != ACT_UNUSED) begin
				sent++;
			end
			burst_left--;
			if (burst_left == 0 && max_gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, max_gap)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 12);
			end
		end
	endtask

	// Drop valid and wait out every frame, plus any dropped request in flight.
	task automatic drain;
		req_ch.valid <= 1'b0;
		while (frame_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_slave_addr(input byte_t addr);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.slave_address <= addr;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		slave_now = addr;
	endtask

	// Receiver: ready pattern changes mode now and then; a requested hold
	// keeps it low for a long stretch.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int hold_seen;
		mode = 0;
		mode_left = 40;
		hold_left = 0;
		hold_seen = 0;
		byte_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				byte_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: byte_ch.ready <= 1'b1;
					1: byte_ch.ready <= ($urandom_range(0, 3) != 0);
					2: byte_ch.ready <= 1'($urandom_range(0, 1));
					default: byte_ch.ready <= ($urandom_range(0, 9) == 0);
				endcase
				mode_left--;
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
			end
		end
	end

	// Compare each byte beat with the oldest expected one.
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (frame_due.size() == 0) begin
				if (errors < MAX_REPORTS) begin
					$display("unexpected frame byte %02h last %0b", byte_ch.frame_byte,
						byte_ch.last_byte);
				end
				errors++;
			end else begin
				want = frame_due.pop_front();
				if (byte_ch.frame_byte !== want.data || byte_ch.last_byte !== want.last) begin
					if (errors < MAX_REPORTS) begin
						$display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
							want.data, want.last, byte_ch.frame_byte, byte_ch.last_byte);
					end
					errors++;
				end
			end
		end
	end

	initial begin
		byte_t addrs [6];
		errors = 0;
		hold_ask = 0;
		slave_now = SLAVE_ADDR_RST;
		req_ch.valid         <= 1'b0;
		req_ch.action        <= ACT_WRITE_COIL;
		req_ch.relay_number  <= 4'd1;
		req_ch.coil_on       <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.slave_address <= SLAVE_ADDR_RST;
		addrs = '{8'h00, 8'hFF, 8'd247, 8'($urandom_range(0, 255)), 8'hA5,
			8'($urandom_range(0, 247))};
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			send_req(dir_rows[r].act, dir_rows[r].relay, dir_rows[r].coil,
				dir_rows[r].typed, dir_rows[r].body);
			if ($urandom_range(0, 2) == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		drain();

		for (int p = 0; p < 6; p++) begin
			write_slave_addr(addrs[p]);
			if (p == 1) begin
				// Receiver holds off while requests keep coming back to back.
				hold_ask++;
				run_stream(24, 0);
				run_stream(26, 10);
			end else begin
				run_stream(50, 10);
			end
			drain();
		end

		if (errors == 0 && frame_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
